[hdl/drct_pkg.sv]
// Shared types, field codes and character constants of the row/column tokenizer.
package drct_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] END_FIELD = 2'd0;
  localparam logic [1:0] END_ROW   = 2'd1;
  localparam logic [1:0] END_WIDTH = 2'd2;
  localparam logic [1:0] END_DATA  = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_DELIM   = 3'd1;
  localparam logic [2:0] ST_TOO_FEW    = 3'd2;
  localparam logic [2:0] ST_TOO_MANY   = 3'd3;
  localparam logic [2:0] ST_INCOMPLETE = 3'd4;

  localparam logic [2:0] REG_COL_SEP      = 3'd0;
  localparam logic [2:0] REG_LINE_SEP     = 3'd1;
  localparam logic [2:0] REG_QUOTE_CHAR   = 3'd2;
  localparam logic [2:0] REG_ESCAPE_CHAR  = 3'd3;
  localparam logic [2:0] REG_SKIP_SPACES  = 3'd4;
  localparam logic [2:0] REG_EXPECTED     = 3'd5;
  localparam logic [2:0] REG_MAX_COLUMNS  = 3'd6;
  localparam logic [2:0] REG_FIXED_WIDTHS = 3'd7;

  typedef struct packed {
    logic [7:0]  col_sep;
    logic [7:0]  line_sep;
    logic [7:0]  quote_char;
    logic [7:0]  escape_char;
    logic        skip_leading_spaces;
    logic [7:0]  expected_columns;
    logic [7:0]  max_columns;
    logic [63:0] fixed_widths;
  } cfg_t;

  // Classified input word as handed from the front end to the back end.
  typedef struct packed {
    logic is_end;
    logic is_row;
    logic is_field;
    logic is_quote;
    logic is_escape;
    logic is_lspace;
  } cls_t;

  typedef struct packed {
    logic [7:0]  column_index;
    logic [15:0] column_start;
    logic [15:0] column_length;
    logic [1:0]  end_kind;
    logic [2:0]  row_status;
    logic        last_in_row;
  } res_t;

endpackage

[hdl/drct_fifo.sv]
// Small synchronous queue with simultaneous push and pop.
module drct_fifo #(
  parameter type         T     = logic [7:0],
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output T     rdata_o,
  output logic empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[hdl/drct_front.sv]
// Front end: accepts input words, matches them against the special characters, queues them.
module drct_front import drct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       push,
  output logic       full,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output logic       cls_valid_o,
  output cls_t       cls_o,
  input  logic       cls_pop_i
);

  cls_t cls_in;
  logic cls_empty;
  logic row_hit;

  // A newline delimiter also accepts a carriage return.
  assign row_hit = (cfg_i.line_sep == CH_LF) ?
                   (data_byte_i == CH_LF || data_byte_i == CH_CR) :
                   (data_byte_i == cfg_i.line_sep);

  always_comb begin
    cls_in.is_end    = action_i;
    cls_in.is_row    = row_hit;
    cls_in.is_field  = (data_byte_i == cfg_i.col_sep);
    cls_in.is_quote  = (data_byte_i == cfg_i.quote_char);
    cls_in.is_escape = (data_byte_i == cfg_i.escape_char);
    cls_in.is_lspace = cfg_i.skip_leading_spaces && (data_byte_i == CH_SPACE);
  end

  drct_fifo #(.T(cls_t), .DEPTH(2)) u_cls_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls_in),
    .full_o  (full),
    .pop_i   (cls_pop_i),
    .rdata_o (cls_o),
    .empty_o (cls_empty)
  );

  assign cls_valid_o = !cls_empty;

endmodule

[hdl/drct_back.sv]
// Back end: row and column state machine and the result queue.
module drct_back import drct_pkg::*; #(
  parameter int unsigned ROW_BYTES_MAX = 65536,
  parameter int unsigned FIXED_COLUMNS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        cls_valid_i,
  input  cls_t        cls_i,
  output logic        cls_pop_o,
  output logic        empty,
  input  logic        pop,
  output res_t        res_o
);

  localparam logic [15:0] POS_CAP =
    16'((ROW_BYTES_MAX - 1 > 65535) ? 65535 : ROW_BYTES_MAX - 1);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_COLUMN,
    PH_DISCARD
  } phase_e;

  typedef struct packed {
    logic [2:0] status;
    logic       last;
    logic       more;
    logic       discard;
  } fin_t;

  phase_e      phase_q, phase_d;
  logic        in_quotes_q, in_quotes_d;
  logic        dq_mode_q, dq_mode_d;
  logic        quote_pend_q, quote_pend_d;
  logic        esc_pend_q, esc_pend_d;
  logic        trimming_q, trimming_d;
  logic [7:0]  col_count_q, col_count_d;
  logic [15:0] col_off_q, col_off_d;
  logic [15:0] row_pos_q, row_pos_d;
  logic [7:0]  width_left_q, width_left_d;
  logic        width_full_q, width_full_d;

  logic        step;
  logic        emit;
  res_t        res_d;
  logic        res_full;
  logic        fixed_mode;
  logic        dq_cfg;

  assign fixed_mode = (cfg_i.col_sep == 8'd0);
  assign dq_cfg     = (cfg_i.quote_char == cfg_i.escape_char);
  assign step       = cls_valid_i && !res_full;
  assign cls_pop_o  = step;

  function automatic logic [15:0] adv(logic [15:0] pos);
    return (pos < POS_CAP) ? pos + 16'd1 : pos;
  endfunction

  // Width of a fixed column; columns past the table reuse the last entry, zero acts as one.
  function automatic logic [7:0] width_of(logic [7:0] cnt, logic [63:0] widths);
    logic [2:0] idx;
    logic [7:0] w;
    idx = (cnt < 8'(FIXED_COLUMNS)) ? cnt[2:0] : 3'(FIXED_COLUMNS - 1);
    w   = widths[{idx, 3'b000} +: 8];
    return (w != 8'd0) ? w : 8'd1;
  endfunction

  function automatic fin_t finish_col(logic [1:0] kind, logic [7:0] i, cfg_t c);
    fin_t       f;
    logic       strict;
    logic [7:0] limit;
    logic [8:0] nxt;
    strict = (c.expected_columns != 8'd0);
    limit  = (c.max_columns != 8'd0) ? c.max_columns : 8'd1;
    nxt    = {1'b0, i} + 9'd1;
    f      = '{status: ST_OK, last: 1'b0, more: 1'b0, discard: 1'b0};
    if (kind == END_ROW) begin
      f.last = 1'b1;
      if (strict && nxt != {1'b0, c.expected_columns}) begin
        f.status = (i == 8'd0) ? ST_NO_DELIM : ST_TOO_FEW;
      end
    end else if (strict && nxt == {1'b0, c.expected_columns}) begin
      f.status  = ST_TOO_MANY;
      f.last    = 1'b1;
      f.discard = 1'b1;
    end else if (nxt >= {1'b0, limit}) begin
      f.last    = 1'b1;
      f.discard = 1'b1;
    end else begin
      f.more = 1'b1;
    end
    return f;
  endfunction

  function automatic res_t make_res(logic [7:0] cnt, logic [15:0] off, logic [15:0] pos,
                                    logic [1:0] kind, logic [2:0] status, logic last);
    res_t r;
    r.column_index  = cnt;
    r.column_start  = off;
    r.column_length = pos - off;
    r.end_kind      = kind;
    r.row_status    = status;
    r.last_in_row   = last;
    return r;
  endfunction

  always_comb begin
    fin_t   f;
    logic   go;
    logic   done;
    phase_d      = phase_q;
    in_quotes_d  = in_quotes_q;
    dq_mode_d    = dq_mode_q;
    quote_pend_d = quote_pend_q;
    esc_pend_d   = esc_pend_q;
    trimming_d   = trimming_q;
    col_count_d  = col_count_q;
    col_off_d    = col_off_q;
    row_pos_d    = row_pos_q;
    width_left_d = width_left_q;
    width_full_d = width_full_q;
    emit         = 1'b0;
    res_d        = make_res(col_count_q, col_off_q, row_pos_q, END_DATA, ST_INCOMPLETE, 1'b1);
    f            = '0;
    go           = 1'b0;
    done         = 1'b0;

    if (step) begin
      if (cls_i.is_end) begin
        emit         = (phase_q == PH_COLUMN);
        phase_d      = PH_SKIP;
        in_quotes_d  = 1'b0;
        dq_mode_d    = 1'b0;
        quote_pend_d = 1'b0;
        esc_pend_d   = 1'b0;
        trimming_d   = 1'b0;
        col_count_d  = 8'd0;
        col_off_d    = 16'd0;
        row_pos_d    = 16'd0;
        width_left_d = 8'd0;
        width_full_d = 1'b0;
      end else if (phase_q == PH_DISCARD) begin
        if (cls_i.is_row) begin
          phase_d = PH_SKIP;
        end
      end else begin
        go = 1'b1;
        if (phase_q != PH_COLUMN) begin
          if (cls_i.is_row) begin
            go = 1'b0;
          end else begin
            // First byte of a new row opens column zero at offset zero.
            phase_d      = PH_COLUMN;
            col_count_d  = 8'd0;
            row_pos_d    = 16'd0;
            col_off_d    = 16'd0;
            in_quotes_d  = 1'b0;
            dq_mode_d    = 1'b0;
            quote_pend_d = 1'b0;
            esc_pend_d   = 1'b0;
            trimming_d   = 1'b1;
            width_left_d = width_of(8'd0, cfg_i.fixed_widths);
            width_full_d = 1'b0;
          end
        end
      end

      if (go && fixed_mode) begin
        if (cls_i.is_row) begin
          f       = finish_col(END_ROW, col_count_d, cfg_i);
          emit    = 1'b1;
          res_d   = make_res(col_count_d, col_off_d, row_pos_d, END_ROW, f.status, f.last);
          phase_d = PH_SKIP;
        end else begin
          if (width_full_d) begin
            f     = finish_col(END_WIDTH, col_count_d, cfg_i);
            emit  = 1'b1;
            res_d = make_res(col_count_d, col_off_d, row_pos_d, END_WIDTH, f.status, f.last);
            if (f.more) begin
              // The byte that follows a full column opens the next one.
              col_count_d  = col_count_d + 8'd1;
              col_off_d    = row_pos_d;
              in_quotes_d  = 1'b0;
              dq_mode_d    = 1'b0;
              quote_pend_d = 1'b0;
              esc_pend_d   = 1'b0;
              trimming_d   = 1'b1;
              width_left_d = width_of(col_count_d, cfg_i.fixed_widths);
              width_full_d = 1'b0;
            end else begin
              phase_d = PH_DISCARD;
              done    = 1'b1;
            end
          end
          if (!done) begin
            if (width_left_d != 8'd0) begin
              width_left_d = width_left_d - 8'd1;
            end
            width_full_d = (width_left_d == 8'd0);
            row_pos_d    = adv(row_pos_d);
          end
        end
      end else if (go) begin
        if (trimming_d) begin
          if (cls_i.is_lspace) begin
            row_pos_d = adv(row_pos_d);
            done      = 1'b1;
          end else begin
            trimming_d = 1'b0;
            if (cls_i.is_quote) begin
              in_quotes_d = 1'b1;
              dq_mode_d   = dq_cfg;
              row_pos_d   = adv(row_pos_d);
              done        = 1'b1;
            end
          end
        end
        // A quote after a quote in doubled-quote mode is literal content.
        if (!done && quote_pend_d) begin
          quote_pend_d = 1'b0;
          if (cls_i.is_quote) begin
            row_pos_d = adv(row_pos_d);
            done      = 1'b1;
          end else begin
            in_quotes_d = 1'b0;
            dq_mode_d   = 1'b0;
          end
        end
        if (!done && esc_pend_d) begin
          esc_pend_d = 1'b0;
          row_pos_d  = adv(row_pos_d);
          done       = 1'b1;
        end
        if (!done && cls_i.is_quote) begin
          if (dq_mode_d) begin
            quote_pend_d = 1'b1;
          end else begin
            in_quotes_d = 1'b0;
          end
          row_pos_d = adv(row_pos_d);
          done      = 1'b1;
        end
        if (!done && cls_i.is_escape) begin
          esc_pend_d = 1'b1;
          row_pos_d  = adv(row_pos_d);
          done       = 1'b1;
        end
        if (!done && in_quotes_d) begin
          row_pos_d = adv(row_pos_d);
          done      = 1'b1;
        end
        if (!done && cls_i.is_field) begin
          f         = finish_col(END_FIELD, col_count_d, cfg_i);
          emit      = 1'b1;
          res_d     = make_res(col_count_d, col_off_d, row_pos_d, END_FIELD, f.status, f.last);
          row_pos_d = adv(row_pos_d);
          if (f.more) begin
            col_count_d  = col_count_d + 8'd1;
            col_off_d    = row_pos_d;
            in_quotes_d  = 1'b0;
            dq_mode_d    = 1'b0;
            quote_pend_d = 1'b0;
            esc_pend_d   = 1'b0;
            trimming_d   = 1'b1;
            width_left_d = width_of(col_count_d, cfg_i.fixed_widths);
            width_full_d = 1'b0;
          end else begin
            phase_d = PH_DISCARD;
          end
          done = 1'b1;
        end
        if (!done && cls_i.is_row) begin
          f       = finish_col(END_ROW, col_count_d, cfg_i);
          emit    = 1'b1;
          res_d   = make_res(col_count_d, col_off_d, row_pos_d, END_ROW, f.status, f.last);
          phase_d = PH_SKIP;
          done    = 1'b1;
        end
        if (!done) begin
          row_pos_d = adv(row_pos_d);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SKIP;
      in_quotes_q  <= 1'b0;
      dq_mode_q    <= 1'b0;
      quote_pend_q <= 1'b0;
      esc_pend_q   <= 1'b0;
      trimming_q   <= 1'b0;
      col_count_q  <= 8'd0;
      col_off_q    <= 16'd0;
      row_pos_q    <= 16'd0;
      width_left_q <= 8'd0;
      width_full_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      in_quotes_q  <= in_quotes_d;
      dq_mode_q    <= dq_mode_d;
      quote_pend_q <= quote_pend_d;
      esc_pend_q   <= esc_pend_d;
      trimming_q   <= trimming_d;
      col_count_q  <= col_count_d;
      col_off_q    <= col_off_d;
      row_pos_q    <= row_pos_d;
      width_left_q <= width_left_d;
      width_full_q <= width_full_d;
    end
  end

  drct_fifo #(.T(res_t), .DEPTH(2)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step && emit),
    .wdata_i (res_d),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule

[hdl/delimited_row_column_tokenizer_unit.sv]
// Top level of the row/column tokenizer: register port, front end and back end.
//
//   channel   | direction | handshake          | words
//   ----------+-----------+--------------------+----------------------------------------
//   input     | in        | push / full        | action_i, data_byte_i
//   result    | out       | pop / empty        | column_* , end_kind_o, row_status_o, ...
//   registers | in / out  | psel, penable, ... | 8 registers at byte address 8*index
//
// One word is taken per clock while full is low; the word is registered in the word queue,
// and its result is registered in the result queue when the back end handles it. The rate
// is set by the back end's state update, which handles one classified word each cycle
// while the result queue has room. Reset is asynchronous and active low and returns all
// registers to their defaults and the row state to its start. A stalled result side fills
// the two-entry result queue and then the two-entry word queue, after which full is raised.
module delimited_row_column_tokenizer_unit import drct_pkg::*; #(
  parameter int unsigned ROW_BYTES_MAX = 65536,
  parameter int unsigned FIXED_COLUMNS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  column_index_o,
  output logic [15:0] column_start_o,
  output logic [15:0] column_length_o,
  output logic [1:0]  end_kind_o,
  output logic [2:0]  row_status_o,
  output logic        last_in_row_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       cls_valid;
  cls_t       cls;
  logic       cls_pop;
  res_t       res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col_sep             <= 8'd44;
      cfg_q.line_sep            <= 8'd10;
      cfg_q.quote_char          <= 8'd34;
      cfg_q.escape_char         <= 8'd92;
      cfg_q.skip_leading_spaces <= 1'b0;
      cfg_q.expected_columns    <= 8'd0;
      cfg_q.max_columns         <= 8'd255;
      cfg_q.fixed_widths        <= 64'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_COL_SEP:      cfg_q.col_sep             <= pwdata[7:0];
        REG_LINE_SEP:     cfg_q.line_sep            <= pwdata[7:0];
        REG_QUOTE_CHAR:   cfg_q.quote_char          <= pwdata[7:0];
        REG_ESCAPE_CHAR:  cfg_q.escape_char         <= pwdata[7:0];
        REG_SKIP_SPACES:  cfg_q.skip_leading_spaces <= pwdata[0];
        REG_EXPECTED:     cfg_q.expected_columns    <= pwdata[7:0];
        REG_MAX_COLUMNS:  cfg_q.max_columns         <= pwdata[7:0];
        REG_FIXED_WIDTHS: cfg_q.fixed_widths        <= pwdata;
        default:          cfg_q.fixed_widths        <= cfg_q.fixed_widths;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COL_SEP:      prdata = {56'd0, cfg_q.col_sep};
      REG_LINE_SEP:     prdata = {56'd0, cfg_q.line_sep};
      REG_QUOTE_CHAR:   prdata = {56'd0, cfg_q.quote_char};
      REG_ESCAPE_CHAR:  prdata = {56'd0, cfg_q.escape_char};
      REG_SKIP_SPACES:  prdata = {63'd0, cfg_q.skip_leading_spaces};
      REG_EXPECTED:     prdata = {56'd0, cfg_q.expected_columns};
      REG_MAX_COLUMNS:  prdata = {56'd0, cfg_q.max_columns};
      REG_FIXED_WIDTHS: prdata = cfg_q.fixed_widths;
      default:          prdata = 64'd0;
    endcase
  end

  drct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .cls_valid_o (cls_valid),
    .cls_o       (cls),
    .cls_pop_i   (cls_pop)
  );

  drct_back #(
    .ROW_BYTES_MAX (ROW_BYTES_MAX),
    .FIXED_COLUMNS (FIXED_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cls_valid_i (cls_valid),
    .cls_i       (cls),
    .cls_pop_o   (cls_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign column_index_o  = res.column_index;
  assign column_start_o  = res.column_start;
  assign column_length_o = res.column_length;
  assign end_kind_o      = res.end_kind;
  assign row_status_o    = res.row_status;
  assign last_in_row_o   = res.last_in_row;

endmodule
